### design/wfc_pkg.sv
`timescale 1ns / 1ps

package wfc_pkg;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register word index within the configuration space
  localparam logic REG_DIRECTION = 1'b0;

  localparam logic [7:0]  FRAME_HEAD_TEXT = 8'h81;
  localparam logic [63:0] LEN_SHORT_MAX   = 64'd125;
  localparam logic [63:0] LEN_MID_MAX     = 64'd65535;
  localparam logic [7:0]  LEN_CODE_16     = 8'd126;
  localparam logic [7:0]  LEN_CODE_64     = 8'd127;
  localparam logic [6:0]  LEN_CODE_MASK   = 7'h7F;

  localparam logic [3:0] HDR_N_SHORT = 4'd2;
  localparam logic [3:0] HDR_N_MID   = 4'd4;
  localparam logic [3:0] HDR_N_LONG  = 4'd10;

  localparam logic [3:0] MASK_START_RESET = 4'd2;
  localparam logic [3:0] MASK_START_16    = 4'd4;
  localparam logic [3:0] MASK_START_64    = 4'd10;
  localparam logic [3:0] BYTE_INDEX_MAX   = 4'd14;

  typedef enum logic {
    DIR_DECODE = 1'b0,
    DIR_ENCODE = 1'b1
  } dir_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        first_of_message;
    logic        last_of_message;
    logic [62:0] payload_length;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } result_t;

endpackage

### design/wfc_if.sv
`timescale 1ns / 1ps

interface wfc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic        first_of_message;
  logic        last_of_message;
  logic [62:0] payload_length;

  modport source(output valid, data_byte, byte_valid, first_of_message, last_of_message,
                 payload_length, input ready);
  modport sink(input valid, data_byte, byte_valid, first_of_message, last_of_message,
               payload_length, output ready);
endinterface

interface wfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source(output valid, out_byte, out_last, input ready);
  modport sink(input valid, out_byte, out_last, output ready);
endinterface

### design/wfc_regs.sv
`timescale 1ns / 1ps

module wfc_regs
  import wfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output dir_t               direction
);

  logic hit;

  assign hit    = (paddr[PADDR_W-1] == REG_DIRECTION);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_DECODE;
    end else if (psel && penable && pwrite && hit) begin
      direction <= dir_t'(pwdata[0]);
    end
  end

  assign prdata = hit ? {{(PDATA_W-1){1'b0}}, direction} : '0;

endmodule

### design/wfc_encoder.sv
`timescale 1ns / 1ps

module wfc_encoder
  import wfc_pkg::*;
(
  input  item_t      item,
  input  logic [3:0] k,
  output logic [3:0] n,
  output result_t    res
);

  logic [63:0] len;
  logic        is_short;
  logic        is_mid;
  logic [3:0]  hdr_n;
  logic [3:0]  long_sel;
  logic [7:0]  long_byte;

  assign len      = {1'b0, item.payload_length};
  assign is_short = (len <= LEN_SHORT_MAX);
  assign is_mid   = (len <= LEN_MID_MAX);
  assign long_sel = HDR_N_LONG - 4'd1 - k;
  assign long_byte = len[long_sel[2:0]*8 +: 8];

  always_comb begin
    if (is_short) hdr_n = HDR_N_SHORT;
    else if (is_mid) hdr_n = HDR_N_MID;
    else hdr_n = HDR_N_LONG;
  end

  assign n = item.first_of_message ? hdr_n + {3'b0, item.byte_valid} : {3'b0, item.byte_valid};

  always_comb begin
    res.out_byte = item.data_byte;
    res.out_last = item.last_of_message;
    if (item.first_of_message && k < hdr_n) begin
      // header bytes; the final one closes an empty message
      res.out_last = (k == hdr_n - 4'd1) && !item.byte_valid && item.last_of_message;
      priority if (k == 4'd0) begin
        res.out_byte = FRAME_HEAD_TEXT;
      end else if (k == 4'd1) begin
        if (is_short) res.out_byte = len[7:0];
        else if (is_mid) res.out_byte = LEN_CODE_16;
        else res.out_byte = LEN_CODE_64;
      end else if (is_mid) begin
        res.out_byte = (k == 4'd2) ? len[15:8] : len[7:0];
      end else begin
        res.out_byte = long_byte;
      end
    end
  end

endmodule

### design/wfc_decoder.sv
`timescale 1ns / 1ps

module wfc_decoder
  import wfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  logic    commit,
  output logic    has_result,
  output result_t res
);

  logic [3:0] byte_index, byte_index_next;
  logic [3:0] mask_start, mask_start_next;
  logic [1:0] payload_phase, payload_phase_next;
  logic [7:0] mask_key [4];
  logic [7:0] mask_key_next [4];

  logic [3:0] idx;
  logic [3:0] ms;
  logic [1:0] ph;
  logic [3:0] key_pos;
  logic [6:0] code;

  // a first item restarts the header walk before its byte is handled
  assign idx     = item.first_of_message ? 4'd0 : byte_index;
  assign ms      = item.first_of_message ? MASK_START_RESET : mask_start;
  assign ph      = item.first_of_message ? 2'd0 : payload_phase;
  assign key_pos = idx - ms;
  assign code    = item.data_byte[6:0] & LEN_CODE_MASK;

  assign has_result   = item.byte_valid && (idx >= ms + 4'd4);
  assign res.out_byte = item.data_byte ^ mask_key[ph];
  assign res.out_last = item.last_of_message;

  always_comb begin
    byte_index_next    = idx;
    mask_start_next    = ms;
    payload_phase_next = ph;
    for (int j = 0; j < 4; j++) mask_key_next[j] = mask_key[j];

    if (idx == 4'd1) begin
      if (code == LEN_CODE_16[6:0]) mask_start_next = MASK_START_16;
      else if (code == LEN_CODE_64[6:0]) mask_start_next = MASK_START_64;
      else mask_start_next = MASK_START_RESET;
    end else if (idx > 4'd1 && idx < ms + 4'd4) begin
      if (idx >= ms) mask_key_next[key_pos[1:0]] = item.data_byte;
    end else if (idx >= ms + 4'd4) begin
      payload_phase_next = ph + 2'd1;
    end

    if (idx < BYTE_INDEX_MAX) byte_index_next = idx + 4'd1;

    if (item.last_of_message) begin
      byte_index_next    = 4'd0;
      mask_start_next    = MASK_START_RESET;
      payload_phase_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= 4'd0;
      mask_start    <= MASK_START_RESET;
      payload_phase <= 2'd0;
      for (int j = 0; j < 4; j++) mask_key[j] <= 8'd0;
    end else if (commit && item.byte_valid) begin
      byte_index    <= byte_index_next;
      mask_start    <= mask_start_next;
      payload_phase <= payload_phase_next;
      for (int j = 0; j < 4; j++) mask_key[j] <= mask_key_next[j];
    end
  end

endmodule

### design/websocket_frame_codec_top.sv
`timescale 1ns / 1ps

// WebSocket frame codec, byte stream in, byte stream out.
// data_ch carries one item per handshake: a byte with valid, first and last flags,
// and on encode the message payload length (sampled on the first item).
// result_ch carries one result byte per handshake with its last flag.
// The direction register (APB, address 0, bit 0) selects decode (0) or encode (1);
// write it only while the block is idle.
// An item is registered in the input register on acceptance, and its results pass
// through the output register to result_ch.
// Throughput: one item per cycle whenever an item yields at most one result and
// result_ch does not stall. An encode first item yields its header burst (2, 4 or
// 10 bytes, plus the payload byte) out of the single output register, one per cycle
// while result_ch accepts, and holds data_ch off until its last byte is registered.
// Decode drops header bytes, captures the mask key and unmasks payload bytes.
// Reset clears the direction to decode and the decode position, mask start,
// phase and mask key. When result_ch stalls, the output register holds its item,
// the input register fills and data_ch ready drops; nothing is lost.
module websocket_frame_codec_top
  import wfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  wfc_in_if.sink             data_ch,
  wfc_out_if.source          result_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  dir_t    direction;
  logic    a_valid;
  item_t   a_item;
  logic [3:0] k;
  logic [3:0] n;
  logic [3:0] enc_n;
  result_t enc_res;
  result_t dec_res;
  result_t cur_res;
  logic    dec_has;
  logic    o_valid;
  result_t o_res;
  logic    o_free;
  logic    emit;
  logic    a_done;
  logic    take;
  item_t   in_item;

  wfc_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .direction(direction)
  );

  wfc_encoder u_enc (
    .item(a_item), .k(k), .n(enc_n), .res(enc_res)
  );

  wfc_decoder u_dec (
    .clk(clk), .rst(rst), .item(a_item),
    .commit(a_done && direction == DIR_DECODE),
    .has_result(dec_has), .res(dec_res)
  );

  assign in_item.data_byte        = data_ch.data_byte;
  assign in_item.byte_valid       = data_ch.byte_valid;
  assign in_item.first_of_message = data_ch.first_of_message;
  assign in_item.last_of_message  = data_ch.last_of_message;
  assign in_item.payload_length   = data_ch.payload_length;

  assign n       = (direction == DIR_ENCODE) ? enc_n : {3'b0, dec_has};
  assign cur_res = (direction == DIR_ENCODE) ? enc_res : dec_res;

  assign o_free = !o_valid || result_ch.ready;
  assign emit   = a_valid && (n != 4'd0) && o_free;
  // the item leaves the input register with its final result, or at once if it has none
  assign a_done = a_valid && ((n == 4'd0) || (emit && k == n - 4'd1));
  assign take   = data_ch.valid && data_ch.ready;

  assign data_ch.ready = !a_valid || a_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      k       <= 4'd0;
    end else begin
      if (take) a_valid <= 1'b1;
      else if (a_done) a_valid <= 1'b0;
      if (a_done) k <= 4'd0;
      else if (emit) k <= k + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) a_item <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_free) begin
      o_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) o_res <= cur_res;
  end

  assign result_ch.valid    = o_valid;
  assign result_ch.out_byte = o_res.out_byte;
  assign result_ch.out_last = o_res.out_last;

endmodule
